// File: rtl/hmbf_pkg.sv
package hmbf_pkg;

  localparam int CHAN_IN_W = 6;
  localparam int SAMPLE_W  = 12;
  localparam int WLEN_W    = 10;
  localparam int GAIN_W    = 8;
  localparam int SPLIT_W   = 7;
  localparam int CODE_W    = 16;
  localparam int COUNT_W   = 10;
  localparam int FILL_W    = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
  localparam logic [FILL_W-1:0]  FILL_MAX  = 10'd1023;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_FIRST    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_SECOND   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GROUP_SPLIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_CODE      = 3'd4;

  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctrl_t;

endpackage

// File: rtl/histogram_mode_baseline_filter_core.sv
// Histogram-mode baseline filter.
// Input channel: in_valid/in_stall carry one sample beat (channel, 12-bit sample,
// last_in_record). Output channel: out_valid/out_stall carry one result beat per
// input beat (filtered, out_channel, out_record_end), in input order.
// Configuration: APB-style port, registers at byte addresses 0,4,8,12,16; pready
// is tied high. Write registers only while the block is idle.
// Each beat does a read-modify-write eviction, when the window is full, and an
// insertion in the per-channel histogram memory, then scans all BINS bins of that
// channel through the single histogram memory port to find the mode. A beat steps
// through channel folding (one CHANNELS subtract per step while the index is at or
// above CHANNELS), the ring read, the eviction read and, when it evicts, the
// eviction write, then the insertion read and write, the scan, the scan end, the
// multiply and the final sum. One beat is in flight at a time; in_stall drops as
// out_valid rises. After reset a clearing pass zeroes the histogram and sample ring
// memories over 2**max(log2(CHANNELS)+log2(BINS), log2(MAX_WINDOW)+log2(CHANNELS))
// addresses (262144 at the defaults). in_stall stays high during it; config writes
// are still taken. A result held by out_stall sits in the output register; the next
// beat is accepted meanwhile and its work waits only at the final load.
module histogram_mode_baseline_filter_core #(
  parameter int CHANNELS   = 64,
  parameter int MAX_WINDOW = 512,
  parameter int BINS       = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hmbf_pkg::CHAN_IN_W-1:0]  in_channel,
  input  logic [hmbf_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                            in_last_in_record,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hmbf_pkg::CODE_W-1:0]     out_filtered,
  output logic [hmbf_pkg::CHAN_IN_W-1:0]  out_channel,
  output logic                            out_record_end,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hmbf_pkg::APB_AW-1:0]     paddr,
  input  logic [hmbf_pkg::APB_DW-1:0]     pwdata,
  output logic [hmbf_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import hmbf_pkg::*;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHR_W   = (CH_W > CHAN_IN_W) ? CH_W : CHAN_IN_W;
  localparam int BIN_W   = $clog2(BINS);
  localparam int SE_W    = (BIN_W > SAMPLE_W) ? BIN_W : SAMPLE_W;
  localparam int POS_W   = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int HIST_AW = CH_W + BIN_W;
  localparam int RING_AW = POS_W + CH_W;
  localparam int CLR_AW  = (HIST_AW > RING_AW) ? HIST_AW : RING_AW;
  localparam int D_W     = SE_W + 1;
  localparam int P_W     = D_W + GAIN_W + 1;
  localparam int S_W     = ((P_W > CODE_W + 1) ? P_W : CODE_W + 1) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REDUCE, S_RING_RD, S_EVICT_RD, S_EVICT_WR,
    S_ADD_RD, S_ADD_WR, S_SCAN, S_SCAN_END, S_MUL, S_SUM
  } state_t;

  // ---------------- configuration registers ----------------
  logic [WLEN_W-1:0]  wlen_r;
  logic [GAIN_W-1:0]  gain_a_r;
  logic [GAIN_W-1:0]  gain_b_r;
  logic [SPLIT_W-1:0] split_r;
  logic [CODE_W-1:0]  max_code_r;
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r     <= 10'd2;
      gain_a_r   <= 8'd1;
      gain_b_r   <= 8'd1;
      split_r    <= 7'd32;
      max_code_r <= 16'd4095;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WINDOW_LENGTH: wlen_r     <= pwdata[WLEN_W-1:0];
        REG_GAIN_FIRST:    gain_a_r   <= pwdata[GAIN_W-1:0];
        REG_GAIN_SECOND:   gain_b_r   <= pwdata[GAIN_W-1:0];
        REG_GROUP_SPLIT:   split_r    <= pwdata[SPLIT_W-1:0];
        REG_MAX_CODE:      max_code_r <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_LENGTH: prdata = APB_DW'(wlen_r);
      REG_GAIN_FIRST:    prdata = APB_DW'(gain_a_r);
      REG_GAIN_SECOND:   prdata = APB_DW'(gain_b_r);
      REG_GROUP_SPLIT:   prdata = APB_DW'(split_r);
      REG_MAX_CODE:      prdata = APB_DW'(max_code_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------- control and item registers ----------------
  state_t               state_r;
  logic [CLR_AW-1:0]    clr_r;
  logic [CHAN_IN_W-1:0] chan_r;
  logic [CHR_W-1:0]     ch_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [BIN_W-1:0]     bin_r;
  logic                 last_r;
  logic [BIN_W-1:0]     old_bin_r;
  logic                 old_ok_r;
  logic [SAMPLE_W-1:0]  tap_val_r;
  logic [BIN_W-1:0]     scan_idx_r;
  logic [BIN_W-1:0]     scan_idx_d_r;
  logic                 scan_vld_r;
  logic signed [P_W-1:0] prod_r;
  logic [FILL_W-1:0]    fill_r;
  logic [POS_W-1:0]     ring_pos_r;
  logic                 out_valid_r;
  logic [CODE_W-1:0]    filtered_r;
  logic [CHAN_IN_W-1:0] out_chan_r;
  logic                 out_end_r;

  // window geometry
  logic [WIN_W-1:0] win, half, pos_eff, tap_w, pos_inc, pos_next;
  logic             evicting;
  logic [CH_W-1:0]  ch;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] tap;

  always_comb begin
    if (wlen_r < 10'd2) begin
      win = WIN_W'(2);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(wlen_r);
    end
    half    = win >> 1;
    pos_eff = (WIN_W'(ring_pos_r) >= win) ? '0 : WIN_W'(ring_pos_r);
    // tap stays below win, so neither branch overflows
    tap_w   = (pos_eff >= half) ? (pos_eff - half) : (pos_eff + (win - half));
    pos_inc = pos_eff + WIN_W'(1);
    pos_next = (pos_inc >= win) ? '0 : pos_inc;
  end

  assign evicting = (32'(fill_r) >= 32'(win));
  assign ch  = CH_W'(ch_r);
  assign pos = POS_W'(pos_eff);
  assign tap = POS_W'(tap_w);

  // sample saturation to the bin range
  logic [SE_W-1:0] samp_ext, samp_sat;
  assign samp_ext = SE_W'(in_sample);
  assign samp_sat = (samp_ext > SE_W'(BINS - 1)) ? SE_W'(BINS - 1) : samp_ext;

  // ---------------- memories ----------------
  logic [HIST_AW-1:0]  hist_addr;
  logic                hist_we;
  logic [COUNT_W-1:0]  hist_wdata;
  logic [COUNT_W-1:0]  hist_rdata;
  logic [RING_AW-1:0]  ring_addr;
  logic                ring_we;
  logic [SAMPLE_W-1:0] ring_wdata;
  logic [SAMPLE_W-1:0] ring_rdata;

  logic [SE_W-1:0]  old_ext;
  logic [BIN_W-1:0] old_bin;
  logic             old_ok;

  assign old_ext = SE_W'(ring_rdata);
  assign old_ok  = (old_ext <= SE_W'(BINS - 1));
  assign old_bin = old_ok ? BIN_W'(old_ext) : BIN_W'(BINS - 1);

  always_comb begin
    hist_addr  = {ch, bin_r};
    hist_we    = 1'b0;
    hist_wdata = '0;
    ring_addr  = {pos, ch};
    ring_we    = 1'b0;
    ring_wdata = sample_r;
    unique case (state_r)
      S_CLEAR: begin
        // wrapped addresses just get zeroed again
        hist_addr  = clr_r[HIST_AW-1:0];
        hist_we    = 1'b1;
        ring_addr  = clr_r[RING_AW-1:0];
        ring_we    = 1'b1;
        ring_wdata = '0;
      end
      S_EVICT_RD: begin
        hist_addr = {ch, old_bin};
        ring_we   = 1'b1;
      end
      S_EVICT_WR: begin
        hist_addr  = {ch, old_bin_r};
        hist_we    = old_ok_r;
        hist_wdata = (hist_rdata == '0) ? '0 : hist_rdata - COUNT_W'(1);
      end
      S_ADD_RD: begin
        ring_addr = {tap, ch};
      end
      S_ADD_WR: begin
        hist_we    = 1'b1;
        hist_wdata = (hist_rdata < COUNT_MAX) ? hist_rdata + COUNT_W'(1) : hist_rdata;
      end
      S_SCAN: begin
        hist_addr = {ch, scan_idx_r};
      end
      default: ;
    endcase
  end

  hmbf_ram #(.W(COUNT_W), .AW(HIST_AW)) u_hist (
    .clk   (clk),
    .addr  (hist_addr),
    .we    (hist_we),
    .wdata (hist_wdata),
    .rdata (hist_rdata)
  );

  hmbf_ram #(.W(SAMPLE_W), .AW(RING_AW)) u_ring (
    .clk   (clk),
    .addr  (ring_addr),
    .we    (ring_we),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  // ---------------- mode scan ----------------
  scan_ctrl_t       scan_ctrl;
  logic [BIN_W-1:0] mode;

  assign scan_ctrl.clear = (state_r == S_ADD_WR);
  assign scan_ctrl.valid = scan_vld_r;

  hmbf_mode_scan #(.BIN_W(BIN_W)) u_scan (
    .clk   (clk),
    .ctrl  (scan_ctrl),
    .idx   (scan_idx_d_r),
    .count (hist_rdata),
    .mode  (mode)
  );

  // ---------------- arithmetic ----------------
  logic [GAIN_W-1:0]     gain;
  logic signed [D_W-1:0] diff;
  logic signed [S_W-1:0] sum, sat;
  logic [FILL_W-1:0]     fill_dec, fill_nxt;
  logic                  out_free;

  assign gain = ({1'b0, chan_r} < split_r) ? gain_a_r : gain_b_r;
  assign diff = $signed({1'b0, SE_W'(tap_val_r)}) - $signed({1'b0, SE_W'(mode)});

  always_comb begin
    sum = S_W'(prod_r) + $signed(S_W'(max_code_r >> 1));
    sat = (sum >= $signed(S_W'(max_code_r))) ? $signed(S_W'(max_code_r)) - S_W'(2) : sum;
    if (sat < 0) begin
      sat = '0;
    end
  end

  always_comb begin
    fill_dec = (evicting && (fill_r != '0)) ? fill_r - FILL_W'(1) : fill_r;
    fill_nxt = (fill_dec < FILL_MAX) ? fill_dec + FILL_W'(1) : fill_dec;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fill_r      <= '0;
      ring_pos_r  <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      scan_vld_r   <= (state_r == S_SCAN);
      scan_idx_d_r <= scan_idx_r;
      // the final step reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != S_SUM)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_AW'(1);
          if (&clr_r) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            chan_r   <= in_channel;
            ch_r     <= CHR_W'(in_channel);
            sample_r <= SAMPLE_W'(samp_sat);
            bin_r    <= BIN_W'(samp_sat);
            last_r   <= in_last_in_record;
            state_r  <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // fold the channel into range, one subtract per cycle
          if (32'(ch_r) >= CHANNELS) begin
            ch_r <= ch_r - CHR_W'(CHANNELS);
          end else begin
            state_r <= S_RING_RD;
          end
        end
        S_RING_RD: begin
          state_r <= S_EVICT_RD;
        end
        S_EVICT_RD: begin
          old_bin_r <= old_bin;
          old_ok_r  <= old_ok;
          state_r   <= evicting ? S_EVICT_WR : S_ADD_RD;
        end
        S_EVICT_WR: begin
          state_r <= S_ADD_RD;
        end
        S_ADD_RD: begin
          state_r <= S_ADD_WR;
        end
        S_ADD_WR: begin
          tap_val_r  <= ring_rdata;
          scan_idx_r <= '0;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          scan_idx_r <= scan_idx_r + BIN_W'(1);
          if (scan_idx_r == BIN_W'(BINS - 1)) begin
            state_r <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= P_W'(diff) * $signed({1'b0, gain});
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            filtered_r  <= CODE_W'(sat);
            out_chan_r  <= chan_r;
            out_end_r   <= last_r;
            if (last_r) begin
              fill_r     <= fill_nxt;
              ring_pos_r <= POS_W'(pos_next);
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = filtered_r;
  assign out_channel    = out_chan_r;
  assign out_record_end = out_end_r;

  // ---------------- assertions ----------------
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result beat presented during memory clearing pass");

  a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SUM))
    else $error("output register loaded outside the final step");

  a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (fill_r >= $past(fill_r)))
    else $error("window fill count decreased");

endmodule

// File: rtl/hmbf_ram.sv
module hmbf_ram #(
  parameter int W  = 10,
  parameter int AW = 18
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/hmbf_mode_scan.sv
module hmbf_mode_scan #(
  parameter int BIN_W = 12
) (
  input  logic                        clk,
  input  hmbf_pkg::scan_ctrl_t        ctrl,
  input  logic [BIN_W-1:0]            idx,
  input  logic [hmbf_pkg::COUNT_W-1:0] count,
  output logic [BIN_W-1:0]            mode
);
  import hmbf_pkg::*;

  logic [COUNT_W-1:0] best_r;
  logic [BIN_W-1:0]   mode_r;

  // strict greater-than keeps the lowest bin among equal counts
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      best_r <= '0;
      mode_r <= '0;
    end else if (ctrl.valid && (count > best_r)) begin
      best_r <= count;
      mode_r <= idx;
    end
  end

  assign mode = mode_r;

endmodule

// File: dv/histogram_mode_baseline_filter_core_tb.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hmbf_pkg::*;

  localparam int CHANNELS    = 64;
  localparam int MAX_WINDOW  = 512;
  localparam int BINS        = 4096;
  localparam int BEAT_CYCLES = BINS + 16;

  typedef struct packed {
    logic [CHAN_IN_W-1:0] chan;
    logic [SAMPLE_W-1:0]  smp;
    logic                 last;
  } sample_beat_t;

  typedef struct packed {
    logic [CODE_W-1:0]    filtered;
    logic [CHAN_IN_W-1:0] chan;
    logic                 rec_end;
  } filter_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAN_IN_W-1:0]  in_channel = '0;
  logic [SAMPLE_W-1:0]   in_sample = '0;
  logic                  in_last_in_record = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CODE_W-1:0]     out_filtered;
  logic [CHAN_IN_W-1:0]  out_channel;
  logic                  out_record_end;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  histogram_mode_baseline_filter_core #(
    .CHANNELS  (CHANNELS),
    .MAX_WINDOW(MAX_WINDOW),
    .BINS      (BINS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .in_last_in_record(in_last_in_record),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered),
    .out_channel      (out_channel),
    .out_record_end   (out_record_end),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // predictor state, mirrors the block from reset
  bit [COUNT_W-1:0]  bin_count [CHANNELS][BINS];
  bit [SAMPLE_W-1:0] ring_val [MAX_WINDOW][CHANNELS];
  int fill_cnt = 0;
  int ring_pos = 0;

  // register shadows, reset values
  int win_len     = 2;
  int gain_lo_grp = 1;
  int gain_hi_grp = 1;
  int split_ch    = 32;
  int code_max    = 4095;

  sample_beat_t   sample_q[$];
  filter_result_t filtered_q[$];
  sample_beat_t   next_beat;
  filter_result_t want;

  int  gap_left = 0;
  int  stall_left = 0;
  bit  quiet = 1'b0;
  int  errors = 0;
  int  beats_sent = 0;
  int  records_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_baseline_result(input sample_beat_t bt);
    int win, pos, tap, best, mode, gain, b;
    longint acc;
    bit evict;
    filter_result_t res;
    win = (win_len < 2) ? 2 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
    pos = (ring_pos >= win) ? 0 : ring_pos;
    evict = (fill_cnt >= win);
    if (evict && bin_count[bt.chan][ring_val[pos][bt.chan]] > 0)
      bin_count[bt.chan][ring_val[pos][bt.chan]]--;
    ring_val[pos][bt.chan] = bt.smp;
    if (bin_count[bt.chan][bt.smp] < COUNT_MAX)
      bin_count[bt.chan][bt.smp]++;
    // lowest bin wins a tie
    best = 0;
    mode = 0;
    for (b = 0; b < BINS; b++) begin
      if (bin_count[bt.chan][b] > best) begin
        best = bin_count[bt.chan][b];
        mode = b;
      end
    end
    tap = (pos >= win / 2) ? pos - win / 2 : pos + win - win / 2;
    gain = (bt.chan < split_ch) ? gain_lo_grp : gain_hi_grp;
    acc = (longint'(ring_val[tap][bt.chan]) - mode) * gain + code_max / 2;
    if (acc >= code_max) acc = code_max - 2;
    if (acc < 0) acc = 0;
    if (bt.last) begin
      if (evict && fill_cnt > 0) fill_cnt--;
      if (fill_cnt < FILL_MAX) fill_cnt++;
      ring_pos = (pos + 1 >= win) ? 0 : pos + 1;
    end
    res.filtered = acc[CODE_W-1:0];
    res.chan     = bt.chan;
    res.rec_end  = bt.last;
    filtered_q.push_back(res);
  endfunction

  // sample beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_baseline_result({in_channel, in_sample, in_last_in_record});
        beats_sent++;
        if (in_last_in_record) records_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          next_beat = sample_q.pop_front();
          in_channel <= next_beat.chan;
          in_sample <= next_beat.smp;
          in_last_in_record <= next_beat.last;
          in_valid <= 1'b1;
          gap_left = quiet ? 0 : $urandom_range(0, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result beats; the stall drawn after one beat holds the next one on arrival
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result filtered=%0d channel=%0d record_end=%0b",
                   $time, out_filtered, out_channel, out_record_end);
        end else begin
          want = filtered_q.pop_front();
          results_seen++;
          if (out_filtered !== want.filtered || out_channel !== want.chan ||
              out_record_end !== want.rec_end) begin
            errors++;
            $display("%0t: expected %0d ch %0d end %0b, got %0d ch %0d end %0b",
                     $time, want.filtered, want.chan, want.rec_end,
                     out_filtered, out_channel, out_record_end);
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 8);
        out_stall <= (stall_left > 0);
      end else if (out_valid && out_stall) begin
        stall_left--;
        out_stall <= (stall_left > 0);
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH: win_len     = value & 32'h3FF;
      REG_GAIN_FIRST:    gain_lo_grp = value & 32'hFF;
      REG_GAIN_SECOND:   gain_hi_grp = value & 32'hFF;
      REG_GROUP_SPLIT:   split_ch    = value & 32'h7F;
      REG_MAX_CODE:      code_max    = value & 32'hFFFF;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || filtered_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic push_beat(input int chan, input int smp, input bit last);
    sample_beat_t bt;
    bt.chan = CHAN_IN_W'(chan);
    bt.smp  = SAMPLE_W'(smp);
    bt.last = last;
    sample_q.push_back(bt);
  endtask

  // mostly ascending records over a few channels with clustered values, some noise
  task automatic queue_records(input int n_items);
    logic [CHAN_IN_W-1:0] chans[$];
    logic [CHAN_IN_W-1:0] kept[$];
    int base [CHANNELS];
    int done, n;
    n = $urandom_range(1, 3);
    repeat (n) chans.push_back(CHAN_IN_W'($urandom_range(0, 63)));
    chans.sort();
    foreach (base[i]) base[i] = $urandom_range(0, 4093);
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat($urandom_range(0, 63), $urandom_range(0, 4095), $urandom_range(0, 1));
        done++;
      end else begin
        kept.delete();
        foreach (chans[i])
          if ((i == 0 || chans[i] != chans[i-1]) && $urandom_range(0, 4) != 0)
            kept.push_back(chans[i]);
        if (kept.size() == 0) kept.push_back(chans[chans.size()-1]);
        foreach (kept[i]) begin
          push_beat(kept[i],
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                : base[kept[i]] + $urandom_range(0, 2),
                    i == kept.size() - 1);
          done++;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: window of two, both saturation sides, ties on the mode
    quiet = 1'b1;
    push_beat(0, 4095, 1);
    push_beat(0, 0, 1);
    push_beat(0, 100, 1);
    push_beat(21, 12'h555, 0);
    push_beat(42, 12'hAAA, 0);
    push_beat(63, 12'hFFF, 1);
    drain();

    // oversized window acts as the maximum, tap still in the zero fill
    quiet = 1'b0;
    write_reg(REG_WINDOW_LENGTH, 1023);
    write_reg(REG_GAIN_FIRST, 255);
    write_reg(REG_GAIN_SECOND, 0);
    write_reg(REG_GROUP_SPLIT, 127);
    write_reg(REG_MAX_CODE, 65535);
    push_beat(1, 10, 1);
    push_beat(1, 20, 1);
    push_beat(63, 4095, 0);
    push_beat(2, 7, 1);
    push_beat(0, 4095, 1);
    drain();

    // shrink to two: ring position past the window wraps to slot zero
    write_reg(REG_WINDOW_LENGTH, 1);
    write_reg(REG_GAIN_FIRST, 3);
    write_reg(REG_GAIN_SECOND, 200);
    write_reg(REG_GROUP_SPLIT, 0);
    write_reg(REG_MAX_CODE, 1);
    push_beat(1, 10, 1);
    push_beat(63, 0, 1);
    push_beat(1, 4095, 1);
    drain();

    write_reg(REG_WINDOW_LENGTH, 0);
    write_reg(REG_GAIN_SECOND, 255);
    write_reg(REG_MAX_CODE, 0);
    push_beat(5, 300, 1);
    push_beat(5, 300, 1);

    for (int p = 0; p < 5; p++) begin
      drain();
      quiet = (p == 2);
      write_reg(REG_WINDOW_LENGTH,
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(2, 6));
      write_reg(REG_GAIN_FIRST,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4));
      write_reg(REG_GAIN_SECOND,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4));
      write_reg(REG_GROUP_SPLIT, $urandom_range(0, 127));
      case ($urandom_range(0, 3))
        0: write_reg(REG_MAX_CODE, $urandom_range(0, 65535));
        1: write_reg(REG_MAX_CODE, 4095);
        2: write_reg(REG_MAX_CODE, 65535);
        default: write_reg(REG_MAX_CODE, $urandom_range(2, 8191));
      endcase
      queue_records(28);
    end

    drain();
    repeat (BEAT_CYCLES + 64) @(posedge clk);
    $display("Ran %0d sample beats in %0d records through %0d register writes.",
             beats_sent, records_sent, cfg_writes);
    $display("Compared %0d filtered results, %0d errors.", results_seen, errors);
    if (errors == 0) begin
      $display("** histogram_mode_baseline_filter_core: PASSED **");
    end else begin
      $display("** histogram_mode_baseline_filter_core: FAILED **");
    end
    $finish;
  end

  // clearing pass plus every beat at full latency and stalls, several times over
  initial begin
    #50_000_000;
    $display("Timeout with %0d results still expected.", filtered_q.size());
    $display("** histogram_mode_baseline_filter_core: FAILED **");
    $finish;
  end

endmodule

// File: files.f
rtl/hmbf_pkg.sv
rtl/hmbf_ram.sv
rtl/hmbf_mode_scan.sv
rtl/histogram_mode_baseline_filter_core.sv
dv/histogram_mode_baseline_filter_core_tb.sv
